>>> design/segmem_pkg.sv
// segmem_pkg: shared types, codes and sizes for the segmented data memory
// used by segmem_ctrl, segmem_datapath and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package segmem_pkg;

   // byte offset width inside one region, legal range 12 to 20
   localparam int OFFSET_BITS = 20;
   localparam int LANES       = 4;
   localparam int LANE_BITS   = 2;
   localparam int WORD_BITS   = OFFSET_BITS - LANE_BITS;
   localparam int STORE_WORDS = 1 << WORD_BITS;
   localparam int REGIONS     = 3;

   localparam logic [11:0] REGION_TEXT  = 12'h004;
   localparam logic [11:0] REGION_DATA  = 12'h100;
   localparam logic [11:0] REGION_STACK = 12'h7ff;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;
   localparam logic [1:0] SIZE_BAD  = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_UNMAPPED = 2'd1;
   localparam logic [1:0] STATUS_BADSIZE  = 2'd2;

   localparam logic ACTION_READ  = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   typedef struct packed {
      logic capture;   // latch the request fields
      logic access;    // memory read or write cycle
      logic format;    // build and register the result
   } cmd_type;

endpackage

`default_nettype wire

>>> design/segmem_ctrl.sv
// segmem_ctrl: sequencing state machine for one access at a time
// depends on segmem_pkg for the command struct
`timescale 1ns / 1ps
`default_nettype none

module segmem_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   output segmem_pkg::cmd_type      cmd,
   output logic                     rsp_strobe
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_ACCESS = 3'b010,
      ST_FORMAT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   always_comb begin
      busy        = (state_ff != ST_IDLE);
      cmd.capture = start && !busy;
      cmd.access  = (state_ff == ST_ACCESS);
      cmd.format  = (state_ff == ST_FORMAT);
      strobe_in   = cmd.format;
      case (state_ff)
         ST_IDLE:   state_in = start ? ST_ACCESS : ST_IDLE;
         ST_ACCESS: state_in = ST_FORMAT;
         ST_FORMAT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe = strobe_ff;

endmodule

`default_nettype wire

>>> design/segmem_datapath.sv
// segmem_datapath: request registers, region decode, byte-lane stores and
// result formatting; depends on segmem_pkg and is driven by segmem_ctrl
`timescale 1ns / 1ps
`default_nettype none

module segmem_datapath (
   input  wire logic                clock,
   input  wire segmem_pkg::cmd_type cmd,
   input  wire logic                req_action,
   input  wire logic [31:0]         req_address,
   input  wire logic [31:0]         req_write_data,
   input  wire logic [1:0]          req_size,
   output logic signed [31:0]       rsp_read_data,
   output logic [1:0]               rsp_status
);

   logic        action_ff;
   logic [31:0] address_ff;
   logic [31:0] wdata_ff;
   logic [1:0]  size_ff;

   logic [segmem_pkg::REGIONS-1:0]   hit;
   logic                             ok;
   logic [segmem_pkg::WORD_BITS-1:0] word_idx;
   logic [segmem_pkg::LANE_BITS-1:0] lane_off;
   logic [segmem_pkg::LANES-1:0]     lane_en;
   logic [7:0]                       lane_wd [segmem_pkg::LANES];
   logic [7:0]                       rd_ff   [segmem_pkg::REGIONS][segmem_pkg::LANES];
   logic [7:0]                       lane_rd [segmem_pkg::LANES];

   logic signed [31:0] read_data_ff, read_data_in;
   logic [1:0]         status_ff, status_in;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff  <= req_action;
         address_ff <= req_address;
         wdata_ff   <= req_write_data;
         size_ff    <= req_size;
      end
   end

   always_comb begin
      hit[0]   = (address_ff[31:20] == segmem_pkg::REGION_TEXT);
      hit[1]   = (address_ff[31:20] == segmem_pkg::REGION_DATA);
      hit[2]   = (address_ff[31:20] == segmem_pkg::REGION_STACK);
      ok       = (|hit) && (size_ff != segmem_pkg::SIZE_BAD);
      word_idx = address_ff[segmem_pkg::OFFSET_BITS-1:segmem_pkg::LANE_BITS];
      lane_off = address_ff[segmem_pkg::LANE_BITS-1:0];
      for (int l = 0; l < segmem_pkg::LANES; l++) begin
         case (size_ff)
            segmem_pkg::SIZE_BYTE: begin
               lane_en[l] = (lane_off == 2'(l));
               lane_wd[l] = wdata_ff[7:0];
            end
            segmem_pkg::SIZE_HALF: begin
               // halfword sits in lanes 0-1 or 2-3
               lane_en[l] = (lane_off[1] == 1'(l >> 1));
               lane_wd[l] = wdata_ff[8*(l%2) +: 8];
            end
            segmem_pkg::SIZE_WORD: begin
               lane_en[l] = 1'b1;
               lane_wd[l] = wdata_ff[8*l +: 8];
            end
            default: begin
               lane_en[l] = 1'b0;
               lane_wd[l] = wdata_ff[7:0];
            end
         endcase
      end
   end

   for (genvar r = 0; r < segmem_pkg::REGIONS; r++) begin : g_region
      for (genvar l = 0; l < segmem_pkg::LANES; l++) begin : g_lane
         logic [7:0] mem_ram [segmem_pkg::STORE_WORDS];
         always_ff @(posedge clock) begin
            if (cmd.access) begin
               if (ok && hit[r] && lane_en[l] && (action_ff == segmem_pkg::ACTION_WRITE)) begin
                  mem_ram[word_idx] <= lane_wd[l];
               end
               rd_ff[r][l] <= mem_ram[word_idx];
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < segmem_pkg::LANES; l++) begin
         lane_rd[l] = 8'd0;
         for (int r = 0; r < segmem_pkg::REGIONS; r++) begin
            lane_rd[l] = lane_rd[l] | (hit[r] ? rd_ff[r][l] : 8'd0);
         end
      end
      read_data_in = '0;
      if (!(|hit)) begin
         status_in = segmem_pkg::STATUS_UNMAPPED;
      end else if (size_ff == segmem_pkg::SIZE_BAD) begin
         status_in = segmem_pkg::STATUS_BADSIZE;
      end else begin
         status_in = segmem_pkg::STATUS_OK;
      end
      if (ok && (action_ff == segmem_pkg::ACTION_READ)) begin
         case (size_ff)
            segmem_pkg::SIZE_BYTE:
               read_data_in = 32'(signed'(lane_rd[lane_off]));
            segmem_pkg::SIZE_HALF:
               read_data_in = lane_off[1]
                  ? 32'(signed'({lane_rd[3], lane_rd[2]}))
                  : 32'(signed'({lane_rd[1], lane_rd[0]}));
            segmem_pkg::SIZE_WORD:
               read_data_in = {lane_rd[3], lane_rd[2], lane_rd[1], lane_rd[0]};
            default:
               read_data_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.format) begin
         read_data_ff <= read_data_in;
         status_ff    <= status_in;
      end
   end

   assign rsp_read_data = read_data_ff;
   assign rsp_status    = status_ff;

endmodule

`default_nettype wire

>>> design/segmented_memory_sized_access_top.sv
// segmented_memory_sized_access_top: segmented byte/half/word data memory
// ties segmem_ctrl and segmem_datapath together; depends on segmem_pkg
//
//   channel   handshake        payload
//   request   start / busy     req_action, req_address, req_write_data, req_size
//   result    rsp_strobe       rsp_read_data, rsp_status
//
// one access steps through capture, memory cycle and format; the result strobe
// is high in the cycle after format, and busy is already low then
// the byte-lane stores have a registered read port, which sets the middle cycle
// reset is synchronous and clears only control; store contents are undefined
// until written, and there is no clearing pass
// the receiver cannot stall: each result is strobed for exactly one cycle
`timescale 1ns / 1ps
`default_nettype none

module segmented_memory_sized_access_top (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire logic          req_action,
   input  wire logic [31:0]   req_address,
   input  wire logic [31:0]   req_write_data,
   input  wire logic [1:0]    req_size,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_read_data,
   output logic [1:0]         rsp_status
);

   segmem_pkg::cmd_type cmd;

   segmem_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe)
   );

   segmem_datapath u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .req_action     (req_action),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .req_size       (req_size),
      .rsp_read_data  (rsp_read_data),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire

>>> design/segmem_checker.sv
// segmem_checker: port-level checks of the segmented memory over time
// depends on segmem_pkg; bound to segmented_memory_sized_access_top
`timescale 1ns / 1ps
`default_nettype none

module segmem_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_strobe,
   input wire logic [31:0] rsp_read_data,
   input wire logic [1:0]  rsp_status
);

   logic accept;
   assign accept = start && !busy;

   // every accepted transfer yields its result strobe after the access and format states
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_strobe)
      else $error("result strobe missing after accepted transfer");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after accepted transfer");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != segmem_pkg::STATUS_OK) |->
         (rsp_read_data == 32'd0) &&
         ((rsp_status == segmem_pkg::STATUS_UNMAPPED) ||
          (rsp_status == segmem_pkg::STATUS_BADSIZE)))
      else $error("error result with bad status code or nonzero data");

endmodule

bind segmented_memory_sized_access_top segmem_checker u_segmem_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_read_data (rsp_read_data),
   .rsp_status    (rsp_status)
);

`default_nettype wire

>>> dv/segmem_reply_checker.sv
// segmem_reply_checker: watches the request and result channels of the segmented memory,
// predicts each reply from a sparse byte image of the three regions and compares it
// depends on segmem_pkg for region codes, size and status codes and the offset width
`timescale 1ns / 1ps

module segmem_reply_checker
   import segmem_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic        req_action,
   input  wire logic [31:0] req_address,
   input  wire logic [31:0] req_write_data,
   input  wire logic [1:0]  req_size,
   input  wire logic        rsp_strobe,
   input  wire logic [31:0] rsp_read_data,
   input  wire logic [1:0]  rsp_status,
   output int               mismatch_count,
   output int               replies_due
);

   localparam logic [19:0] OFFSET_MASK = 20'((1 << OFFSET_BITS) - 1);

   typedef struct packed {
      logic [31:0] read_data;
      logic [1:0]  status;
   } reply_t;

   reply_t      expected_replies[$];
   // key is {region slot, byte offset}; only bytes that were written exist
   logic [7:0]  region_bytes [logic [21:0]];
   int          mismatches = 0;

   assign mismatch_count = mismatches;

   function automatic reply_t predict_access(input logic act, input logic [31:0] addr,
                                             input logic [31:0] wdata, input logic [1:0] sz);
      reply_t      r;
      int          slot;
      int          nbytes;
      logic [19:0] base;
      logic [21:0] key;
      logic [31:0] word;
      r.read_data = '0;
      r.status    = STATUS_OK;
      word        = '0;
      case (addr[31:20])
         REGION_TEXT:  slot = 0;
         REGION_DATA:  slot = 1;
         REGION_STACK: slot = 2;
         default:      slot = -1;
      endcase
      // region is checked before size
      if (slot < 0) begin
         r.status = STATUS_UNMAPPED;
      end else if (sz == SIZE_BAD) begin
         r.status = STATUS_BADSIZE;
      end else begin
         nbytes = 1 << sz;
         base   = addr[19:0] & OFFSET_MASK & ~20'(nbytes - 1);
         for (int i = 0; i < nbytes; i++) begin
            key = {2'(slot), (base + 20'(i)) & OFFSET_MASK};
            if (act == ACTION_WRITE) begin
               region_bytes[key] = wdata[8*i +: 8];
            end else if (region_bytes.exists(key)) begin
               word[8*i +: 8] = region_bytes[key];
            end
         end
         if (act == ACTION_READ) begin
            case (sz)
               SIZE_BYTE: r.read_data = {{24{word[7]}}, word[7:0]};
               SIZE_HALF: r.read_data = {{16{word[15]}}, word[15:0]};
               default:   r.read_data = word;
            endcase
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      reply_t want;
      if (!reset) begin
         // compare before queueing so a same-edge transfer never masks a missing one
         if (rsp_strobe) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("reply with no access outstanding", rsp_read_data, '0);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_read_data !== want.read_data)
                  report_mismatch("read_data", rsp_read_data, want.read_data);
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
            end
         end
         if (start && !busy)
            expected_replies.push_back(predict_access(req_action, req_address,
                                                      req_write_data, req_size));
      end
      replies_due <= expected_replies.size();
   end

endmodule

>>> dv/segmented_memory_sized_access_top_test.sv
// segmented_memory_sized_access_top_test: drives directed and random accesses into the
// segmented memory and gives the verdict; depends on segmem_pkg, segmem_reply_checker
// and segmented_memory_sized_access_top
`timescale 1ns / 1ps

module segmented_memory_sized_access_top_test;
   import segmem_pkg::*;

   localparam logic [19:0] OFFSET_MASK = 20'((1 << OFFSET_BITS) - 1);
   localparam int RANDOM_ITEMS = 430;
   localparam int DRAIN_LIMIT  = 1000;

   logic               clock;
   logic               reset          = 1'b1;
   logic               start          = 1'b0;
   logic               req_action     = ACTION_READ;
   logic [31:0]        req_address    = '0;
   logic [31:0]        req_write_data = '0;
   logic [1:0]         req_size       = SIZE_BYTE;
   logic               busy;
   logic               rsp_strobe;
   logic signed [31:0] rsp_read_data;
   logic [1:0]         rsp_status;
   int                 mismatch_count;
   int                 replies_due;

   // bytes already written, so reads never touch undefined contents
   bit                 written [logic [21:0]];
   logic [21:0]        written_keys[$];

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   segmented_memory_sized_access_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .req_size       (req_size),
      .rsp_strobe     (rsp_strobe),
      .rsp_read_data  (rsp_read_data),
      .rsp_status     (rsp_status)
   );

   segmem_reply_checker reply_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .req_size       (req_size),
      .rsp_strobe     (rsp_strobe),
      .rsp_read_data  (rsp_read_data),
      .rsp_status     (rsp_status),
      .mismatch_count (mismatch_count),
      .replies_due    (replies_due)
   );

   function automatic int region_slot(input logic [11:0] code);
      case (code)
         REGION_TEXT:  return 0;
         REGION_DATA:  return 1;
         REGION_STACK: return 2;
         default:      return -1;
      endcase
   endfunction

   // address in a mapped region; bits above the offset width are don't-care aliases
   function automatic logic [31:0] place(input int slot, input logic [19:0] off);
      logic [11:0] code;
      case (slot)
         0:       code = REGION_TEXT;
         1:       code = REGION_DATA;
         default: code = REGION_STACK;
      endcase
      return {code, (20'($urandom()) & ~OFFSET_MASK) | (off & OFFSET_MASK)};
   endfunction

   task automatic transfer(input logic act, input logic [31:0] addr, input logic [31:0] wdata,
                           input logic [1:0] sz);
      int          slot;
      int          nbytes;
      logic [19:0] base;
      logic [21:0] key;
      slot = region_slot(addr[31:20]);
      start          <= 1'b1;
      req_action     <= act;
      req_address    <= addr;
      req_write_data <= wdata;
      req_size       <= sz;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (slot >= 0 && sz != SIZE_BAD && act == ACTION_WRITE) begin
         nbytes = 1 << sz;
         base   = addr[19:0] & OFFSET_MASK & ~20'(nbytes - 1);
         for (int i = 0; i < nbytes; i++) begin
            key = {2'(slot), (base + 20'(i)) & OFFSET_MASK};
            if (!written.exists(key)) begin
               written[key] = 1'b1;
               written_keys.push_back(key);
            end
         end
      end
   endtask

   task automatic pause_sender(input bit quiet);
      if (!quiet && $urandom_range(0, 99) < 30) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic random_access(input bit quiet);
      int          pick;
      int          slot;
      int          nbytes;
      bit          whole;
      logic [21:0] key;
      logic [19:0] base;
      logic [11:0] code;
      logic [1:0]  sz;
      pick = $urandom_range(0, 99);
      if (pick < 40 && written_keys.size() > 0) begin
         // read around a written byte; fall back to a byte read if the span has holes
         key    = written_keys[$urandom_range(0, written_keys.size() - 1)];
         sz     = 2'($urandom_range(0, 2));
         nbytes = 1 << sz;
         base   = key[19:0] & ~20'(nbytes - 1);
         whole  = 1'b1;
         for (int i = 0; i < nbytes; i++)
            if (!written.exists({key[21:20], (base + 20'(i)) & OFFSET_MASK})) whole = 1'b0;
         if (!whole) begin
            sz     = SIZE_BYTE;
            base   = key[19:0];
            nbytes = 1;
         end
         transfer(ACTION_READ, place(key[21:20], base | 20'($urandom_range(0, nbytes - 1))),
                  $urandom(), sz);
      end else if (pick < 85) begin
         slot = $urandom_range(0, 2);
         base = 20'($urandom());
         // half the writes land next to earlier data so reads see overlaps
         if (written_keys.size() > 0 && $urandom_range(0, 1)) begin
            key  = written_keys[$urandom_range(0, written_keys.size() - 1)];
            slot = key[21:20];
            base = key[19:0] ^ 20'($urandom_range(0, 7));
         end
         transfer(ACTION_WRITE, place(slot, base), $urandom(), 2'($urandom_range(0, 2)));
      end else if (pick < 93) begin
         transfer(1'($urandom()), place($urandom_range(0, 2), 20'($urandom())), $urandom(),
                  SIZE_BAD);
      end else begin
         do code = 12'($urandom()); while (region_slot(code) >= 0);
         transfer(1'($urandom()), {code, 20'($urandom())}, $urandom(), 2'($urandom()));
      end
      pause_sender(quiet);
   endtask

   initial begin
      #400000;
      $display("segmented_memory_sized_access_top regression: fail");
      $finish;
   end

   initial begin
      int waited;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // sign extension of every byte lane and both halves
      transfer(ACTION_WRITE, {REGION_TEXT, 20'h00000}, 32'h80ff7f01, SIZE_WORD);
      transfer(ACTION_READ,  {REGION_TEXT, 20'h00000}, 32'h00000000, SIZE_WORD);
      pause_sender(1'b0);
      transfer(ACTION_READ,  {REGION_TEXT, 20'h00000}, 32'hffffffff, SIZE_BYTE);
      transfer(ACTION_READ,  {REGION_TEXT, 20'h00001}, 32'h00000000, SIZE_BYTE);
      transfer(ACTION_READ,  {REGION_TEXT, 20'h00002}, 32'h00000000, SIZE_BYTE);
      pause_sender(1'b0);
      transfer(ACTION_READ,  {REGION_TEXT, 20'h00003}, 32'h00000000, SIZE_BYTE);
      // misaligned halfword and word addresses round down
      transfer(ACTION_READ,  {REGION_TEXT, 20'h00003}, 32'h00000000, SIZE_HALF);
      transfer(ACTION_READ,  {REGION_TEXT, 20'h00001}, 32'h00000000, SIZE_HALF);
      transfer(ACTION_READ,  {REGION_TEXT, 20'h00003}, 32'h00000000, SIZE_WORD);
      // top of a region, word cannot run past its end
      transfer(ACTION_WRITE, {REGION_STACK, 20'hfffff}, 32'hffffffff, SIZE_WORD);
      transfer(ACTION_READ,  {REGION_STACK, 20'hfffff}, 32'h00000000, SIZE_BYTE);
      pause_sender(1'b0);
      transfer(ACTION_READ,  {REGION_STACK, 20'hffffe}, 32'h00000000, SIZE_HALF);
      // narrow writes only touch their own lanes
      transfer(ACTION_WRITE, {REGION_DATA, 20'h00000}, 32'h00000000, SIZE_WORD);
      transfer(ACTION_WRITE, {REGION_DATA, 20'h00001}, 32'h123456a5, SIZE_BYTE);
      transfer(ACTION_WRITE, {REGION_DATA, 20'h00003}, 32'hffff8000, SIZE_HALF);
      transfer(ACTION_READ,  {REGION_DATA, 20'h00002}, 32'h00000000, SIZE_WORD);
      // unmapped regions win over a bad size
      transfer(ACTION_READ,  32'h00000000, 32'h00000000, SIZE_WORD);
      transfer(ACTION_WRITE, 32'hffffffff, 32'hffffffff, SIZE_BYTE);
      transfer(ACTION_WRITE, {12'h005, 20'h00000}, 32'h5a5a5a5a, SIZE_BAD);
      transfer(ACTION_READ,  {12'h7fe, 20'hfffff}, 32'h00000000, SIZE_HALF);
      transfer(ACTION_READ,  {12'h0ff, 20'h00000}, 32'h00000000, SIZE_BAD);
      // bad size in a mapped region stores nothing
      transfer(ACTION_WRITE, {REGION_TEXT, 20'h00000}, 32'h00000000, SIZE_BAD);
      transfer(ACTION_READ,  {REGION_DATA, 20'h00000}, 32'h00000000, SIZE_BAD);
      transfer(ACTION_READ,  {REGION_TEXT, 20'h00000}, 32'h00000000, SIZE_WORD);
      pause_sender(1'b0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         random_access(n >= 100 && n < 200);
         if (n == 250) begin
            // let the pipeline drain completely once
            start <= 1'b0;
            do @(posedge clock); while (replies_due != 0);
         end
      end

      start <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (replies_due != 0 && waited < DRAIN_LIMIT);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && replies_due == 0) begin
         $display("segmented_memory_sized_access_top regression: pass");
      end else begin
         $display("segmented_memory_sized_access_top regression: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
design/segmem_pkg.sv
design/segmem_ctrl.sv
design/segmem_datapath.sv
design/segmented_memory_sized_access_top.sv
design/segmem_checker.sv
dv/segmem_reply_checker.sv
dv/segmented_memory_sized_access_top_test.sv
